// ----- hw/rtl/pad_pkg.sv -----
// Package: shared types, constants and the power step table of the phase-angle dimmer.
`timescale 1ns / 1ps

package pad_pkg;

	localparam int unsigned HALF_PERIOD_TICKS = 10000;

	localparam logic [15:0] HALF_PERIOD    = 16'(HALF_PERIOD_TICKS);
	localparam logic [15:0] FULL_LEVEL_ADD = 16'd100;
	localparam logic [7:0]  LEVEL_OFF      = 8'd0;
	localparam logic [7:0]  LEVEL_FULL     = 8'd255;
	localparam logic [7:0]  GATE_RESET     = 8'd16;

	typedef enum logic [1:0] {
		CFG_DIM_LEVEL   = 2'd0,
		CFG_CROSS_OFS   = 2'd1,
		CFG_GATE_TICKS  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]  dim_level;
		logic [14:0] crossing_offset;
		logic [7:0]  gate_pulse_ticks;
	} cfg_t;

	typedef struct packed {
		logic        gate_drive;
		logic        armed;
		logic [15:0] fire_delay;
	} result_t;

	// Power step table; the last entry only pads it to 128 and its value is never used.
	localparam logic [12:0] STEP_TAB [128] = '{
		13'd845,  13'd1068, 13'd1225, 13'd1352, 13'd1459, 13'd1553, 13'd1638, 13'd1716,
		13'd1788, 13'd1855, 13'd1917, 13'd1976, 13'd2032, 13'd2086, 13'd2138, 13'd2188,
		13'd2236, 13'd2282, 13'd2327, 13'd2370, 13'd2412, 13'd2453, 13'd2493, 13'd2532,
		13'd2570, 13'd2607, 13'd2643, 13'd2679, 13'd2714, 13'd2748, 13'd2782, 13'd2815,
		13'd2848, 13'd2880, 13'd2911, 13'd2942, 13'd2972, 13'd3002, 13'd3032, 13'd3061,
		13'd3090, 13'd3119, 13'd3147, 13'd3175, 13'd3203, 13'd3230, 13'd3257, 13'd3284,
		13'd3311, 13'd3337, 13'd3363, 13'd3389, 13'd3415, 13'd3440, 13'd3465, 13'd3490,
		13'd3515, 13'd3539, 13'd3563, 13'd3587, 13'd3611, 13'd3635, 13'd3659, 13'd3682,
		13'd3705, 13'd3728, 13'd3751, 13'd3774, 13'd3797, 13'd3820, 13'd3843, 13'd3865,
		13'd3887, 13'd3909, 13'd3931, 13'd3953, 13'd3975, 13'd3997, 13'd4019, 13'd4041,
		13'd4062, 13'd4083, 13'd4104, 13'd4125, 13'd4146, 13'd4167, 13'd4188, 13'd4209,
		13'd4230, 13'd4251, 13'd4272, 13'd4292, 13'd4313, 13'd4333, 13'd4354, 13'd4374,
		13'd4395, 13'd4415, 13'd4435, 13'd4455, 13'd4476, 13'd4496, 13'd4516, 13'd4536,
		13'd4556, 13'd4576, 13'd4596, 13'd4615, 13'd4635, 13'd4655, 13'd4675, 13'd4694,
		13'd4714, 13'd4734, 13'd4754, 13'd4773, 13'd4793, 13'd4813, 13'd4832, 13'd4852,
		13'd4872, 13'd4891, 13'd4911, 13'd4931, 13'd4951, 13'd4970, 13'd4990, 13'd0
	};

endpackage

// ----- hw/rtl/pad_chan_if.sv -----
// Interfaces: tick input channel and result output channel.
`timescale 1ns / 1ps

interface pad_in_if;
	logic valid;
	logic ready;
	logic zc_level;

	modport source (output valid, output zc_level, input ready);
	modport sink (input valid, input zc_level, output ready);
endinterface

interface pad_out_if;
	logic        valid;
	logic        ready;
	logic        gate_drive;
	logic        armed;
	logic [15:0] fire_delay;

	modport source (output valid, output gate_drive, output armed, output fire_delay,
		input ready);
	modport sink (input valid, input gate_drive, input armed, input fire_delay,
		output ready);
endinterface

// ----- hw/rtl/phase_angle_dimmer.sv -----
// Top level of the triac phase-angle dimmer: configuration registers and tick pipeline.
//
// Channel      Dir  Payload                           Transfer
// tick_in      in   zc_level                          valid && ready
// result_out   out  gate_drive, armed, fire_delay     valid && ready
// cfg_*        in   cfg_idx, cfg_data (15 bits)       cfg_we
//
// One tick is taken every clock cycle while the pipeline is not stalled; the tick is
// captured in the input register, its result is loaded into the result register
// when the pipeline advances, and from there it can transfer.
// The delay is computed in the same cycle as the crossing: table read, for the lower
// half a subtraction from the half period, one add and a compare-subtract against it.
// Reset clears the counter, arming and pulse, sets the previous detector
// level high and the gate width to 16.
// A stalled result holds in its register; one more tick waits in the input
// register, then tick_in.ready drops.
`timescale 1ns / 1ps

module phase_angle_dimmer import pad_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [14:0]      cfg_data,
	pad_in_if.sink           tick_in,
	pad_out_if.source        result_out
);

	cfg_t    cfg_q;
	result_t res;

	// Write the register picked by the index; an unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim_level        <= LEVEL_OFF;
			cfg_q.crossing_offset  <= 15'd0;
			cfg_q.gate_pulse_ticks <= GATE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DIM_LEVEL:  cfg_q.dim_level        <= cfg_data[7:0];
				CFG_CROSS_OFS:  cfg_q.crossing_offset  <= cfg_data;
				CFG_GATE_TICKS: cfg_q.gate_pulse_ticks <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	pad_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (tick_in.valid),
		.in_ready  (tick_in.ready),
		.in_zc     (tick_in.zc_level),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.out_res   (res)
	);

	assign result_out.gate_drive = res.gate_drive;
	assign result_out.armed      = res.armed;
	assign result_out.fire_delay = res.fire_delay;

endmodule

// ----- hw/rtl/pad_delay.sv -----
// Firing delay from dimming level and crossing offset.
`timescale 1ns / 1ps

module pad_delay import pad_pkg::*; (
	input  logic [7:0]  dim_level,
	input  logic [14:0] crossing_offset,
	output logic [15:0] fire_delay
);

	logic [6:0]  tab_idx;
	logic [12:0] tab_val;
	logic [15:0] addend;
	logic [16:0] sum;
	logic [16:0] wrapped;

	// Upper half counts down the table from its end.
	assign tab_idx = dim_level[7] ? (7'd126 - dim_level[6:0]) : (dim_level[6:0] - 7'd1);
	assign tab_val = STEP_TAB[tab_idx];

	always_comb begin
		if (dim_level == LEVEL_OFF) begin
			addend = 16'd0;
		end else if (dim_level == LEVEL_FULL) begin
			addend = FULL_LEVEL_ADD;
		end else if (dim_level[7]) begin
			addend = {3'd0, tab_val};
		end else begin
			addend = HALF_PERIOD - {3'd0, tab_val};
		end
	end

	assign sum     = {2'd0, crossing_offset} + {1'b0, addend};
	// Subtract the half period once at most.
	assign wrapped = (sum > {1'b0, HALF_PERIOD}) ? (sum - {1'b0, HALF_PERIOD}) : sum;
	assign fire_delay = wrapped[15:0];

endmodule

// ----- hw/rtl/pad_core.sv -----
// Tick pipeline: input register, crossing detect, arming, gate pulse and result register.
`timescale 1ns / 1ps

module pad_core import pad_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    in_zc,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic        valid_s1;
	logic        zc_s1;
	logic        prev_zc_q;
	logic [15:0] tick_q;
	logic [15:0] cmp_q;
	logic        armed_q;
	logic [7:0]  pulse_q;
	logic        out_valid_q;
	result_t     res_q;

	logic        advance;
	logic        fall;
	logic        load;
	logic [15:0] delay;
	logic [15:0] tick_inc;
	logic        hit;
	logic [15:0] tick_n;
	logic [15:0] cmp_n;
	logic        armed_n;
	logic [7:0]  pulse_n;
	logic        gate;

	pad_delay u_delay (
		.dim_level       (cfg.dim_level),
		.crossing_offset (cfg.crossing_offset),
		.fire_delay      (delay)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign fall     = prev_zc_q && !zc_s1;
	assign load     = fall && (cfg.dim_level != LEVEL_OFF);
	assign tick_inc = tick_q + 16'd1;
	assign hit      = !load && armed_q && (tick_inc == cmp_q);

	always_comb begin
		tick_n  = load ? 16'd0 : tick_inc;
		cmp_n   = load ? delay : cmp_q;
		armed_n = load ? 1'b1 : (hit ? 1'b0 : armed_q);
		pulse_n = hit ? cfg.gate_pulse_ticks : pulse_q;
	end

	assign gate = (pulse_n != 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			zc_s1 <= in_zc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_zc_q   <= 1'b1;
			tick_q      <= 16'd0;
			cmp_q       <= 16'd0;
			armed_q     <= 1'b0;
			pulse_q     <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				prev_zc_q   <= zc_s1;
				tick_q      <= tick_n;
				cmp_q       <= cmp_n;
				armed_q     <= armed_n;
				pulse_q     <= gate ? (pulse_n - 8'd1) : pulse_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.gate_drive <= gate;
			res_q.armed      <= armed_n;
			res_q.fire_delay <= cmp_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

// ----- hw/rtl/pad_checker.sv -----
// Port checker for the dimmer, bound to the top level.
`timescale 1ns / 1ps

module pad_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] fire_delay
);

	// A pending result stays until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fire_delay))
		else $error("result dropped or changed while stalled");

	// With the result register empty the input side must be open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("tick input blocked with empty result register");

	// The input side closes only behind a stalled result.
	a_block_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("tick input blocked without output stall");

	// After a stall clears, a waiting tick keeps the output busy.
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && in_valid |=> out_valid)
		else $error("waiting tick produced no result");

endmodule

bind phase_angle_dimmer pad_checker u_pad_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (tick_in.valid),
	.in_ready   (tick_in.ready),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.fire_delay (result_out.fire_delay)
);
